/* rtl/core/smas_pkg.sv */
// Shared constants, codes and types of the stroke smoother.
`timescale 1ns / 1ps
package smas_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int XY_W       = 20;
	localparam int P_W        = 16;
	localparam int SXY_W      = XY_W + IDX_W;
	localparam int SP_W       = P_W + IDX_W;
	localparam int DIV_STEPS  = SXY_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_PRESS = 2'd1,
		CMD_DRAIN = 2'd2,
		CMD_RESET = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL,
		S_RD,
		S_RD_SRC,
		S_RD_DST,
		S_UPD,
		S_START,
		S_DIV,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		ADDR_NEWEST,
		ADDR_DST,
		ADDR_FILL
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_HOLD,
		WD_PRESS,
		WD_SRC
	} wd_sel_t;

	typedef enum logic [1:0] {
		SUM_HOLD,
		SUM_CLEAR,
		SUM_ACC,
		SUM_SWAP
	} sum_op_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic [P_W-1:0]         p;
	} ring_t;

	typedef struct packed {
		logic      accept;
		logic      clear;
		logic      idx_dec;
		cnt_op_t   cnt_op;
		logic      fill_adv;
		logic      rd_en;
		logic      wr_en;
		addr_sel_t addr_sel;
		wd_sel_t   wd_sel;
		sum_op_t   sum_op;
		logic      src_cap;
		logic      div_start;
		logic      out_load;
	} dp_ctl_t;

	typedef struct packed {
		logic cnt_zero;
		logic fill_last;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

/* rtl/core/smas_if.sv */
// Valid/ready channel interfaces for input points and averaged results.
`timescale 1ns / 1ps
interface smas_in_if;
	import smas_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [1:0]             command;
	logic signed [XY_W-1:0] in_x;
	logic signed [XY_W-1:0] in_y;
	logic [P_W-1:0]         in_pressure;

	modport source (output valid, command, in_x, in_y, in_pressure, input ready);
	modport sink (input valid, command, in_x, in_y, in_pressure, output ready);
endinterface

interface smas_out_if;
	import smas_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [XY_W-1:0] out_x;
	logic signed [XY_W-1:0] out_y;
	logic [P_W-1:0]         out_pressure;
	logic [CNT_W-1:0]       points_left;

	modport source (output valid, out_x, out_y, out_pressure, points_left, input ready);
	modport sink (input valid, out_x, out_y, out_pressure, points_left, output ready);
endinterface

/* rtl/core/smas_div.sv */
// Three-lane restoring serial divider of the running sums by the window length.
`timescale 1ns / 1ps
module smas_div
	import smas_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [CNT_W-1:0]        divisor,
	input  logic signed [SXY_W-1:0] num_x,
	input  logic signed [SXY_W-1:0] num_y,
	input  logic [SP_W-1:0]         num_p,
	output logic                    done,
	output logic signed [XY_W-1:0]  quo_x,
	output logic signed [XY_W-1:0]  quo_y,
	output logic [P_W-1:0]          quo_p
);

	localparam int LANES = 3;

	logic [SXY_W-1:0]  quo_q [LANES];
	logic [CNT_W-1:0]  rem_q [LANES];
	logic              neg_q [LANES];
	logic [CNT_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [SXY_W-1:0]  mag   [LANES];
	logic              sgn   [LANES];
	logic [CNT_W:0]    trial [LANES];
	logic              qbit  [LANES];
	logic [CNT_W-1:0]  rem_d [LANES];
	logic [SXY_W-1:0]  res   [LANES];

	always_comb begin
		sgn[0] = num_x[SXY_W-1];
		sgn[1] = num_y[SXY_W-1];
		sgn[2] = 1'b0;
		mag[0] = sgn[0] ? SXY_W'(-num_x) : num_x;
		mag[1] = sgn[1] ? SXY_W'(-num_y) : num_y;
		mag[2] = {{(SXY_W - SP_W){1'b0}}, num_p};
		for (int i = 0; i < LANES; i++) begin
			trial[i] = {rem_q[i], quo_q[i][SXY_W-1]};
			qbit[i]  = trial[i] >= {1'b0, div_q};
			rem_d[i] = qbit[i] ? CNT_W'(trial[i] - {1'b0, div_q}) : CNT_W'(trial[i]);
			res[i]   = neg_q[i] ? SXY_W'(-quo_q[i]) : quo_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_W'(DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// while busy, shift one dividend bit into each remainder per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			for (int i = 0; i < LANES; i++) begin
				quo_q[i] <= mag[i];
				rem_q[i] <= '0;
				neg_q[i] <= sgn[i];
			end
		end else if (busy_q) begin
			for (int i = 0; i < LANES; i++) begin
				quo_q[i] <= {quo_q[i][SXY_W-2:0], qbit[i]};
				rem_q[i] <= rem_d[i];
			end
		end
	end

	assign done  = done_q;
	assign quo_x = res[0][XY_W-1:0];
	assign quo_y = res[1][XY_W-1:0];
	assign quo_p = res[2][P_W-1:0];

endmodule

/* rtl/core/smas_dp.sv */
// Datapath: point ring memory, running sums, index and count, divider, result register.
`timescale 1ns / 1ps
module smas_dp
	import smas_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CNT_W-1:0]       cfg_wdata,
	input  logic signed [XY_W-1:0] in_x,
	input  logic signed [XY_W-1:0] in_y,
	input  logic [P_W-1:0]         in_pressure,
	input  dp_ctl_t                ctl,
	output dp_stat_t               stat,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic signed [XY_W-1:0] out_x,
	output logic signed [XY_W-1:0] out_y,
	output logic [P_W-1:0]         out_pressure,
	output logic [CNT_W-1:0]       points_left
);

	ring_t ring_mem [MAX_WINDOW];

	logic [CNT_W-1:0]        win_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        fill_q;
	logic signed [SXY_W-1:0] sum_x_q;
	logic signed [SXY_W-1:0] sum_y_q;
	logic [SP_W-1:0]         sum_p_q;
	ring_t                   hold_q;
	ring_t                   src_q;
	ring_t                   rd_data_q;
	logic                    out_valid_q;
	logic signed [XY_W-1:0]  out_x_q;
	logic signed [XY_W-1:0]  out_y_q;
	logic [P_W-1:0]          out_p_q;
	logic [CNT_W-1:0]        out_cnt_q;

	logic [CNT_W-1:0]        win_d;
	logic [CNT_W-1:0]        dst_sum;
	logic [IDX_W-1:0]        dst_idx;
	logic [IDX_W-1:0]        addr;
	ring_t                   wdata;
	logic signed [SXY_W-1:0] wx_ext, wy_ext, rx_ext, ry_ext;
	logic [SP_W-1:0]         wp_ext, rp_ext;
	logic                    div_done;
	logic signed [XY_W-1:0]  quo_x, quo_y;
	logic [P_W-1:0]          quo_p;

	// saturate the window length into 1..MAX_WINDOW
	always_comb begin
		if (cfg_wdata == '0)
			win_d = CNT_W'(1);
		else if (cfg_wdata > CNT_W'(MAX_WINDOW))
			win_d = CNT_W'(MAX_WINDOW);
		else
			win_d = cfg_wdata;
	end

	// oldest real slot: (newest + count) mod N, sum stays below 2N
	always_comb begin
		dst_sum = {1'b0, idx_q} + cnt_q;
		if (dst_sum >= win_q)
			dst_idx = IDX_W'(dst_sum - win_q);
		else
			dst_idx = IDX_W'(dst_sum);
	end

	always_comb begin
		case (ctl.addr_sel)
			ADDR_NEWEST: addr = idx_q;
			ADDR_DST:    addr = dst_idx;
			ADDR_FILL:   addr = fill_q;
			default:     addr = idx_q;
		endcase
		case (ctl.wd_sel)
			WD_HOLD:  wdata = hold_q;
			WD_PRESS: wdata = '{x: rd_data_q.x, y: rd_data_q.y, p: hold_q.p};
			WD_SRC:   wdata = src_q;
			default:  wdata = hold_q;
		endcase
		wx_ext = {{IDX_W{wdata.x[XY_W-1]}}, wdata.x};
		wy_ext = {{IDX_W{wdata.y[XY_W-1]}}, wdata.y};
		wp_ext = {{IDX_W{1'b0}}, wdata.p};
		rx_ext = {{IDX_W{rd_data_q.x[XY_W-1]}}, rd_data_q.x};
		ry_ext = {{IDX_W{rd_data_q.y[XY_W-1]}}, rd_data_q.y};
		rp_ext = {{IDX_W{1'b0}}, rd_data_q.p};
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en)
			rd_data_q <= ring_mem[addr];
		if (ctl.wr_en)
			ring_mem[addr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (ctl.accept)
			hold_q <= '{x: in_x, y: in_y, p: in_pressure};
		if (ctl.src_cap)
			src_q <= rd_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= CNT_W'(1);
			cnt_q   <= '0;
			idx_q   <= '0;
			fill_q  <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_p_q <= '0;
		end else if (cfg_we) begin
			win_q   <= win_d;
			cnt_q   <= '0;
			idx_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_p_q <= '0;
		end else if (ctl.clear) begin
			cnt_q   <= '0;
			idx_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_p_q <= '0;
		end else begin
			if (ctl.accept)
				fill_q <= '0;
			else if (ctl.fill_adv)
				fill_q <= fill_q + 1'b1;

			if (ctl.idx_dec)
				idx_q <= (idx_q == '0) ? IDX_W'(win_q - 1'b1) : idx_q - 1'b1;

			case (ctl.cnt_op)
				CNT_INC: if (cnt_q < win_q) cnt_q <= cnt_q + 1'b1;
				CNT_DEC: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase

			case (ctl.sum_op)
				SUM_CLEAR: begin
					sum_x_q <= '0;
					sum_y_q <= '0;
					sum_p_q <= '0;
				end
				SUM_ACC: begin
					sum_x_q <= sum_x_q + wx_ext;
					sum_y_q <= sum_y_q + wy_ext;
					sum_p_q <= sum_p_q + wp_ext;
				end
				SUM_SWAP: begin
					sum_x_q <= sum_x_q + wx_ext - rx_ext;
					sum_y_q <= sum_y_q + wy_ext - ry_ext;
					sum_p_q <= sum_p_q + wp_ext - rp_ext;
				end
				default: begin
					sum_x_q <= sum_x_q;
				end
			endcase
		end
	end

	smas_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.div_start),
		.divisor (win_q),
		.num_x   (sum_x_q),
		.num_y   (sum_y_q),
		.num_p   (sum_p_q),
		.done    (div_done),
		.quo_x   (quo_x),
		.quo_y   (quo_y),
		.quo_p   (quo_p)
	);

	// result register: hold until taken, reload in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_x_q   <= quo_x;
			out_y_q   <= quo_y;
			out_p_q   <= quo_p;
			out_cnt_q <= cnt_q;
		end
	end

	always_comb begin
		stat.cnt_zero  = cnt_q == '0;
		stat.fill_last = {1'b0, fill_q} == CNT_W'(win_q - 1'b1);
		stat.div_done  = div_done;
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign out_pressure = out_p_q;
	assign points_left  = out_cnt_q;

endmodule

/* rtl/core/smas_ctrl.sv */
// Controller state machine sequencing ring access, sum update and division.
`timescale 1ns / 1ps
module smas_ctrl
	import smas_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic [1:0] in_command,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl
);

	state_t state_q, state_d;
	cmd_t   cmd_q;
	cmd_t   in_cmd;

	assign in_cmd = cmd_t'(in_command);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_valid)
				cmd_q <= in_cmd;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						CMD_ADD:   state_d = stat.cnt_zero ? S_FILL : S_RD;
						CMD_PRESS: state_d = stat.cnt_zero ? S_START : S_RD;
						CMD_DRAIN: state_d = stat.cnt_zero ? S_START : S_RD_SRC;
						default:   state_d = S_START;
					endcase
				end
			end
			S_FILL:   if (stat.fill_last) state_d = S_START;
			S_RD:     state_d = S_UPD;
			S_RD_SRC: state_d = S_RD_DST;
			S_RD_DST: state_d = S_UPD;
			S_UPD:    state_d = S_START;
			S_START:  state_d = stat.cnt_zero ? S_IDLE : S_DIV;
			S_DIV:    if (stat.div_done) state_d = S_DONE;
			S_DONE:   if (stat.out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ctl      = '{cnt_op: CNT_HOLD, addr_sel: ADDR_NEWEST, wd_sel: WD_HOLD,
			sum_op: SUM_HOLD, default: 1'b0};
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.accept = 1'b1;
					case (in_cmd)
						CMD_ADD: begin
							// first point pads the whole ring
							if (stat.cnt_zero)
								ctl.sum_op = SUM_CLEAR;
							else
								ctl.idx_dec = 1'b1;
						end
						CMD_DRAIN: if (!stat.cnt_zero) ctl.cnt_op = CNT_DEC;
						CMD_RESET: ctl.clear = 1'b1;
						default:   ctl.accept = 1'b1;
					endcase
				end
			end
			S_FILL: begin
				ctl.wr_en    = 1'b1;
				ctl.addr_sel = ADDR_FILL;
				ctl.wd_sel   = WD_HOLD;
				ctl.sum_op   = SUM_ACC;
				ctl.fill_adv = 1'b1;
				if (stat.fill_last)
					ctl.cnt_op = CNT_INC;
			end
			S_RD, S_RD_SRC: begin
				ctl.rd_en    = 1'b1;
				ctl.addr_sel = ADDR_NEWEST;
			end
			S_RD_DST: begin
				ctl.rd_en    = 1'b1;
				ctl.addr_sel = ADDR_DST;
				ctl.src_cap  = 1'b1;
			end
			S_UPD: begin
				ctl.wr_en  = 1'b1;
				ctl.sum_op = SUM_SWAP;
				case (cmd_q)
					CMD_ADD: begin
						ctl.wd_sel = WD_HOLD;
						ctl.cnt_op = CNT_INC;
					end
					CMD_PRESS: ctl.wd_sel = WD_PRESS;
					CMD_DRAIN: begin
						ctl.wd_sel   = WD_SRC;
						ctl.addr_sel = ADDR_DST;
					end
					default: ctl.wr_en = 1'b0;
				endcase
			end
			S_START: ctl.div_start = !stat.cnt_zero;
			S_DONE:  ctl.out_load = stat.out_free;
			default: in_ready = 1'b0;
		endcase
	end

endmodule

/* rtl/core/stroke_moving_average_smoother_unit.sv */
// Top level of the stroke moving-average smoother.
`timescale 1ns / 1ps
// Sliding-average pen stroke smoother over a ring of the last N points
// (N = window length, 1 to 64, written through cfg_we/cfg_wdata; a write
// also empties the smoother). One item is worked on at a time. Add and set
// pressure read and then write the single ring memory port and drain reads
// it twice and then writes; then the running sums go through a 26-step serial
// divider. The first add after a reset or empty ring writes all N ring
// entries, one per cycle, in place of the ring read and write. Items that
// leave no point held (reset, set pressure or drain on an empty ring, and a
// drain of the last point) give no result. A finished result waits in the
// output register while the next item is taken; the block stalls only when a
// new result is ready before the last is taken.
module stroke_moving_average_smoother_unit
	import smas_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	smas_in_if.sink          sample,
	smas_out_if.source       result
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	smas_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sample.valid),
		.in_command (sample.command),
		.in_ready   (sample.ready),
		.stat       (stat),
		.ctl        (ctl)
	);

	smas_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_x         (sample.in_x),
		.in_y         (sample.in_y),
		.in_pressure  (sample.in_pressure),
		.ctl          (ctl),
		.stat         (stat),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.out_x        (result.out_x),
		.out_y        (result.out_y),
		.out_pressure (result.out_pressure),
		.points_left  (result.points_left)
	);

endmodule
